FILE: hdl/atan2pa_pkg.sv
// shared constants and types for the atan2 polynomial approximation block
package atan2pa_pkg;

  // defaults for the top-level parameters
  localparam int DEF_IN_WIDTH      = 16;
  localparam int DEF_OUT_FRAC_BITS = 13;

  // internal fixed point: unsigned q0.16
  localparam int FRAC      = 16;
  localparam int A_W       = FRAC + 1;   // ratio, 0 .. 1.0 inclusive
  localparam int S_W       = FRAC + 1;   // square of the ratio
  localparam int T_W       = 14;         // inner polynomial term
  localparam int P_W       = 15;         // outer polynomial term
  localparam int PS_W      = P_W + S_W;  // p * s
  localparam int R_W       = 18;         // angle magnitude up to pi in q.16
  localparam int DIV_STEPS = FRAC + 1;   // one quotient bit per step

  // minimax coefficients in q0.16
  localparam logic [11:0]  COEF_C3 = 12'd3047;
  localparam logic [T_W-1:0] COEF_C2 = 14'd10441;
  localparam logic [P_W-1:0] COEF_C1 = 15'd21471;

  // octant constants in q.16
  localparam logic [R_W-1:0] HALF_PI_Q16 = 18'd102944;
  localparam logic [R_W-1:0] PI_Q16      = 18'd205887;

  // octant information that travels with each item
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic swap;   // |y| > |x|
  } side_t;

endpackage

FILE: hdl/atan2_polynomial_approx.sv
// atan2 of a signed (y, x) pair by ratio, minimax polynomial and octant fix
//
// Streaming four-quadrant arctangent. Each transaction on the slave side
// carries one (y, x) pair; one transaction on the master side returns
// atan2(y, x) in radians, signed, with OUT_FRAC_BITS fraction bits (Q3.13 by
// default), in the range -pi .. pi. Both inputs zero give 0. The block is a
// 26-stage pipeline that takes one pair every clock unless back-pressure
// stalls it, and delivers results in order: two stages form magnitudes and
// the min/max ratio operands, 17 stages run a restoring divider one quotient
// bit each (that division sets the depth), five stages evaluate the polynomial
// with one multiplier each, one stage applies the octant fixes and the last
// rescales, applies the sign and holds the result. Each stage stalls only
// when it is full and the stage after it cannot take its contents, so bubbles
// close up and input keeps flowing while a result waits at the output.
module atan2_polynomial_approx #(
  parameter int IN_WIDTH      = atan2pa_pkg::DEF_IN_WIDTH,
  parameter int OUT_FRAC_BITS = atan2pa_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // y_value, then x_value, zero padded to whole bytes
  input  logic [((2*IN_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // angle, zero padded to whole bytes
  output logic [((OUT_FRAC_BITS+3+7)/8)*8-1:0] m_tdata
);

  localparam int W         = IN_WIDTH;
  localparam int OUT_W     = OUT_FRAC_BITS + 3;
  localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8;
  localparam int A_W       = atan2pa_pkg::A_W;
  localparam int S_W       = atan2pa_pkg::S_W;
  localparam int T_W       = atan2pa_pkg::T_W;
  localparam int P_W       = atan2pa_pkg::P_W;
  localparam int PS_W      = atan2pa_pkg::PS_W;
  localparam int R_W       = atan2pa_pkg::R_W;
  localparam int FRAC      = atan2pa_pkg::FRAC;
  localparam int DIV_STEPS = atan2pa_pkg::DIV_STEPS;

  // stage numbering
  localparam int ST_MAG   = 0;
  localparam int ST_ORDER = 1;
  localparam int ST_DIV0  = 2;
  localparam int ST_SQ    = ST_DIV0 + DIV_STEPS;
  localparam int ST_T     = ST_SQ + 1;
  localparam int ST_P     = ST_T + 1;
  localparam int ST_PS    = ST_P + 1;
  localparam int ST_R     = ST_PS + 1;
  localparam int ST_FIX   = ST_R + 1;
  localparam int ST_OUT   = ST_FIX + 1;
  localparam int NS       = ST_OUT + 1;

  // output rescale from q.16
  localparam int RSH  = (OUT_FRAC_BITS < FRAC) ? FRAC - OUT_FRAC_BITS : 0;
  localparam int LSH  = (OUT_FRAC_BITS >= FRAC) ? OUT_FRAC_BITS - FRAC : 0;
  localparam int SC_W = R_W + 1 + LSH;

  // widths of the products
  localparam int SQ_W  = 2 * A_W;
  localparam int C3S_W = 12 + S_W;
  localparam int TS_W  = T_W + S_W;
  localparam int PSA_W = PS_W + A_W;

  localparam logic [SQ_W-1:0]  RND_SQ  = SQ_W'(1) << (FRAC - 1);
  localparam logic [C3S_W-1:0] RND_C3S = C3S_W'(1) << (FRAC - 1);
  localparam logic [TS_W-1:0]  RND_TS  = TS_W'(1) << (FRAC - 1);
  localparam logic [PSA_W-1:0] RND_PSA = PSA_W'(1) << (2 * FRAC - 1);

  // per-stage valid and load enable
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[ST_MAG];
  assign m_tvalid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? s_tvalid : vld[i-1];
        end
      end
    end
  end

  // magnitudes; the most negative input maps to 2^(W-1), which fits W bits
  logic [W-1:0] in_y;
  logic [W-1:0] in_x;
  assign in_y = s_tdata[W-1:0];
  assign in_x = s_tdata[2*W-1:W];

  logic [W-1:0] mag_ay;
  logic [W-1:0] mag_ax;
  logic         mag_yneg;
  logic         mag_xneg;

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mag_yneg <= in_y[W-1];
      mag_xneg <= in_x[W-1];
      mag_ay   <= in_y[W-1] ? W'(~in_y + 1'b1) : in_y;
      mag_ax   <= in_x[W-1] ? W'(~in_x + 1'b1) : in_x;
    end
  end

  // min / max ordering
  logic [W-1:0]       ord_lo;
  logic [W-1:0]       ord_hi;
  logic               ord_zero;
  atan2pa_pkg::side_t ord_side;
  logic               ord_swap_next;

  assign ord_swap_next = mag_ay > mag_ax;

  always_ff @(posedge clk) begin
    if (en[ST_ORDER]) begin
      ord_lo        <= ord_swap_next ? mag_ax : mag_ay;
      ord_hi        <= ord_swap_next ? mag_ay : mag_ax;
      ord_zero      <= (mag_ay == '0) && (mag_ax == '0);
      ord_side.yneg <= mag_yneg;
      ord_side.xneg <= mag_xneg;
      ord_side.swap <= ord_swap_next;
    end
  end

  // restoring divider, one quotient bit per stage: a = floor(lo * 2^16 / hi)
  logic [W-1:0]       dv_rem  [DIV_STEPS];
  logic [W-1:0]       dv_hi   [DIV_STEPS];
  logic [A_W-1:0]     dv_q    [DIV_STEPS];
  logic               dv_zero [DIV_STEPS];
  atan2pa_pkg::side_t dv_side [DIV_STEPS];

  logic [W-1:0]   dv_rem_next [DIV_STEPS];
  logic [A_W-1:0] dv_q_next   [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      logic [W:0] trial;
      logic [W:0] divisor;
      logic       ge;
      // first step compares the unshifted remainder (quotient bit for 1.0)
      if (j == 0) begin
        trial   = {1'b0, ord_lo};
        divisor = {1'b0, ord_hi};
        ge      = trial >= divisor;
        dv_q_next[j] = {{(A_W-1){1'b0}}, ge};
      end else begin
        trial   = {dv_rem[j-1], 1'b0};
        divisor = {1'b0, dv_hi[j-1]};
        ge      = trial >= divisor;
        dv_q_next[j] = {dv_q[j-1][A_W-2:0], ge};
      end
      dv_rem_next[j] = ge ? W'(trial - divisor) : trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[ST_DIV0 + j]) begin
        dv_rem[j]  <= dv_rem_next[j];
        dv_q[j]    <= dv_q_next[j];
        dv_hi[j]   <= (j == 0) ? ord_hi : dv_hi[j-1];
        dv_zero[j] <= (j == 0) ? ord_zero : dv_zero[j-1];
        dv_side[j] <= (j == 0) ? ord_side : dv_side[j-1];
      end
    end
  end

  // s = round(a * a); both inputs zero force the ratio to 0
  logic [A_W-1:0]     sq_a_next;
  logic [SQ_W-1:0]    sq_prod;
  logic [A_W-1:0]     sq_a;
  logic [S_W-1:0]     sq_s;
  atan2pa_pkg::side_t sq_side;

  assign sq_a_next = dv_zero[DIV_STEPS-1] ? '0 : dv_q[DIV_STEPS-1];
  assign sq_prod   = SQ_W'(sq_a_next) * SQ_W'(sq_a_next);

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sq_a    <= sq_a_next;
      sq_s    <= S_W'((sq_prod + RND_SQ) >> FRAC);
      sq_side <= dv_side[DIV_STEPS-1];
    end
  end

  // t = c2 - round(c3 * s)
  logic [C3S_W-1:0]   t_prod;
  logic [A_W-1:0]     t_a;
  logic [S_W-1:0]     t_s;
  logic [T_W-1:0]     t_t;
  atan2pa_pkg::side_t t_side;

  assign t_prod = C3S_W'(atan2pa_pkg::COEF_C3) * C3S_W'(sq_s);

  always_ff @(posedge clk) begin
    if (en[ST_T]) begin
      t_a    <= sq_a;
      t_s    <= sq_s;
      t_t    <= atan2pa_pkg::COEF_C2 - T_W'((t_prod + RND_C3S) >> FRAC);
      t_side <= sq_side;
    end
  end

  // p = c1 - round(t * s)
  logic [TS_W-1:0]    p_prod;
  logic [A_W-1:0]     p_a;
  logic [S_W-1:0]     p_s;
  logic [P_W-1:0]     p_p;
  atan2pa_pkg::side_t p_side;

  assign p_prod = TS_W'(t_t) * TS_W'(t_s);

  always_ff @(posedge clk) begin
    if (en[ST_P]) begin
      p_a    <= t_a;
      p_s    <= t_s;
      p_p    <= atan2pa_pkg::COEF_C1 - P_W'((p_prod + RND_TS) >> FRAC);
      p_side <= t_side;
    end
  end

  // p * s, kept exact
  logic [A_W-1:0]     ps_a;
  logic [PS_W-1:0]    ps_ps;
  atan2pa_pkg::side_t ps_side;

  always_ff @(posedge clk) begin
    if (en[ST_PS]) begin
      ps_a    <= p_a;
      ps_ps   <= PS_W'(p_p) * PS_W'(p_s);
      ps_side <= p_side;
    end
  end

  // r = a - round(p * s * a / 2^32), first-octant angle
  logic [PSA_W-1:0]   r_prod;
  logic [A_W-1:0]     r_corr;
  logic [A_W-1:0]     r_r;
  atan2pa_pkg::side_t r_side;

  assign r_prod = PSA_W'(ps_ps) * PSA_W'(ps_a);
  assign r_corr = A_W'((r_prod + RND_PSA) >> (2 * FRAC));

  always_ff @(posedge clk) begin
    if (en[ST_R]) begin
      r_r    <= ps_a - r_corr;
      r_side <= ps_side;
    end
  end

  // octant fixes: reflect about pi/4, then about pi/2
  logic [R_W-1:0]     fix_oct;
  logic [R_W-1:0]     fix_r;
  logic               fix_yneg;

  assign fix_oct = r_side.swap ? R_W'(atan2pa_pkg::HALF_PI_Q16 - R_W'(r_r)) : R_W'(r_r);

  always_ff @(posedge clk) begin
    if (en[ST_FIX]) begin
      fix_r    <= r_side.xneg ? R_W'(atan2pa_pkg::PI_Q16 - fix_oct) : fix_oct;
      fix_yneg <= r_side.yneg;
    end
  end

  // rescale to the output format, rounding half up when narrowing
  logic [SC_W-1:0] scaled;
  logic [OUT_W-1:0] mag_out;

  generate
    if (RSH > 0) begin : g_round
      localparam logic [SC_W-1:0] RND_OUT = SC_W'(1) << (RSH - 1);
      assign scaled = (SC_W'(fix_r) + RND_OUT) >> RSH;
    end else begin : g_widen
      assign scaled = SC_W'(fix_r) << LSH;
    end
  endgenerate

  assign mag_out = scaled[OUT_W-1:0];

  logic [OUT_W-1:0] angle;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      angle <= fix_yneg ? OUT_W'(OUT_W'(0) - mag_out) : mag_out;
    end
  end

  assign m_tdata = OUT_TD_W'(angle);

endmodule

FILE: sim/tb_atan2_polynomial_approx.sv
// self-checking stream testbench for the atan2 polynomial approximation block
`timescale 1ns / 100ps

module tb_atan2_polynomial_approx;

  // block widths at the default parameters
  localparam int IN_W  = 16;
  localparam int OUT_FB = 13;
  localparam int OUT_W = OUT_FB + 3;

  // first-octant polynomial and octant constants, unsigned q.16
  localparam longint unsigned Q16       = 64'd65536;
  localparam longint unsigned HALF_LSB  = 64'd32768;
  localparam longint unsigned POLY_C3   = 64'd3047;
  localparam longint unsigned POLY_C2   = 64'd10441;
  localparam longint unsigned POLY_C1   = 64'd21471;
  localparam longint unsigned QUARTER_T = 64'd102944;
  localparam longint unsigned HALF_T    = 64'd205887;
  localparam int              DOWN_SH   = 16 - OUT_FB;

  // hold-off for the back-pressure stretch and the drain limits
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_PAIR  = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 40;
  localparam int PAIRS_PER_PHASE = 100;
  localparam int RANDOM_PAIRS  = 900;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one input transaction: y in the low half, x in the high half
  typedef struct packed {
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
  } pair_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // y_value [15:0], x_value [31:16]
  logic [2*IN_W-1:0] s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // angle [15:0]
  logic [OUT_W-1:0]  m_tdata;

  pair_t            pending_pairs[$];
  logic [OUT_W-1:0] expected_angles[$];
  int               pairs_accepted = 0;
  int               mismatch_count = 0;
  int               hold_left = 0;
  logic             hold_done = 1'b0;
  idle_mode_t       idle_mode;

  atan2_polynomial_approx #(
    .IN_WIDTH      (IN_W),
    .OUT_FRAC_BITS (OUT_FB)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // idling mode steps through the four phases as pairs get accepted
  assign idle_mode = idle_mode_t'((pairs_accepted / PAIRS_PER_PHASE) % 4);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // angle of one (y, x) pair in q3.13, worked out in wide unsigned integers
  function automatic logic [OUT_W-1:0] predict_angle(input logic [IN_W-1:0] y,
                                                     input logic [IN_W-1:0] x);
    longint unsigned ay, ax, lo, hi, a, s, t, p, r, m;
    ay = y[IN_W-1] ? (Q16 - longint'(y)) : longint'(y);
    ax = x[IN_W-1] ? (Q16 - longint'(x)) : longint'(x);
    lo = (ax < ay) ? ax : ay;
    hi = (ax > ay) ? ax : ay;
    // ratio of the smaller to the larger magnitude, zero when both are zero
    a = (hi == 0) ? 0 : ((lo << 16) / hi);
    s = (a * a + HALF_LSB) >> 16;
    t = POLY_C2 - ((POLY_C3 * s + HALF_LSB) >> 16);
    p = POLY_C1 - ((t * s + HALF_LSB) >> 16);
    r = a - ((p * s * a + 64'h8000_0000) >> 32);
    // octant fixes: reflect about pi/4, then about the y axis
    if (ay > ax) r = QUARTER_T - r;
    if (x[IN_W-1]) r = HALF_T - r;
    m = (r + (64'd1 << (DOWN_SH - 1))) >> DOWN_SH;
    if (y[IN_W-1]) m = 64'd0 - m;
    return m[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // driver: offers the next pair when free and not idling, predicts on accept
  always @(posedge clk) begin
    logic idle_now;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_angles.push_back(predict_angle(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]));
        pairs_accepted <= pairs_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        // keep pushing without gaps while the receiver holds off
        idle_now = 1'b0;
        if (hold_left == 0) begin
          case (idle_mode)
            IDLE_SENDER: idle_now = ($urandom_range(0, 99) < 68);
            IDLE_BOTH:   idle_now = ($urandom_range(0, 99) < 22);
            default:     idle_now = 1'b0;
          endcase
        end
        if (pending_pairs.size() != 0 && !idle_now) begin
          s_tdata  <= pending_pairs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, so the pipeline fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pairs_accepted >= HOLD_AT_PAIR) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each output transaction against the oldest expectation
  always @(posedge clk) begin
    logic stall_now;
    logic [OUT_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch($sformatf("unexpected angle %0d", $signed(m_tdata)));
        end else begin
          want = expected_angles.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("angle got %0d want %0d",
                                      $signed(m_tdata), $signed(want)));
        end
      end
      case (idle_mode)
        IDLE_RECEIVER: stall_now = ($urandom_range(0, 99) < 68);
        IDLE_BOTH:     stall_now = ($urandom_range(0, 99) < 22);
        default:       stall_now = 1'b0;
      endcase
      m_tready <= (hold_left == 0) && !stall_now;
    end
  end

  // stimulus and end of run
  initial begin
    pair_t pr;
    int    wait_cycles;
    logic [IN_W-1:0] mag;

    // directed: axes, extremes, most negative values, equal magnitudes
    pending_pairs.push_back('{x: 16'sd0,     y: 16'sd0});
    pending_pairs.push_back('{x: 16'sd0,     y: 16'sd32767});
    pending_pairs.push_back('{x: 16'sd0,     y: -16'sd32768});
    pending_pairs.push_back('{x: 16'sd0,     y: -16'sd1});
    pending_pairs.push_back('{x: 16'sd0,     y: 16'sd1});
    pending_pairs.push_back('{x: -16'sd32768, y: 16'sd0});
    pending_pairs.push_back('{x: 16'sd32767, y: 16'sd0});
    pending_pairs.push_back('{x: -16'sd1,    y: 16'sd0});
    pending_pairs.push_back('{x: 16'sd1,     y: 16'sd0});
    pending_pairs.push_back('{x: -16'sd32768, y: -16'sd32768});
    pending_pairs.push_back('{x: 16'sd32767, y: 16'sd32767});
    pending_pairs.push_back('{x: 16'sd32767, y: -16'sd32768});
    pending_pairs.push_back('{x: -16'sd32768, y: 16'sd32767});
    pending_pairs.push_back('{x: 16'sd1,     y: 16'sd1});
    pending_pairs.push_back('{x: -16'sd1,    y: -16'sd1});
    pending_pairs.push_back('{x: -16'sd1,    y: 16'sd1});
    pending_pairs.push_back('{x: 16'sd1,     y: -16'sd1});
    pending_pairs.push_back('{x: 16'sd1,     y: 16'sd32767});
    pending_pairs.push_back('{x: 16'sd32767, y: 16'sd1});
    pending_pairs.push_back('{x: -16'sd1,    y: -16'sd32768});
    pending_pairs.push_back('{x: -16'sd32768, y: -16'sd1});
    pending_pairs.push_back('{x: -16'sd100,  y: 16'sd100});
    pending_pairs.push_back('{x: 16'sd3,     y: 16'sd5});
    pending_pairs.push_back('{x: -16'sd32767, y: 16'sd32766});

    // random: mostly full range, with small values, equal magnitudes and axes
    repeat (RANDOM_PAIRS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          pr.y = 16'($urandom_range(0, 127)) - 16'd64;
          pr.x = 16'($urandom_range(0, 127)) - 16'd64;
        end
        2: begin
          mag  = 16'($urandom_range(1, 32767));
          pr.y = $urandom_range(0, 1) ? mag : -mag;
          pr.x = $urandom_range(0, 1) ? mag : -mag;
        end
        3: begin
          pr.y = 16'($urandom);
          pr.x = 16'($urandom);
          if ($urandom_range(0, 1)) pr.y = '0;
          else pr.x = '0;
        end
        default: begin
          pr.y = 16'($urandom);
          pr.x = 16'($urandom);
        end
      endcase
      pending_pairs.push_back(pr);
    end

    @(negedge rst);
    do @(posedge clk); while (pending_pairs.size() != 0 || s_tvalid);

    wait_cycles = 0;
    while (expected_angles.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    // pipeline depth plus margin, catches any stray output
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_angles.size() != 0)
      report_mismatch($sformatf("%0d angles never arrived", expected_angles.size()));

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_400_000;
    $display("FAILURE");
    $finish;
  end

endmodule
